// ===== src/pvq_pkg.sv =====
// ----------------------------------------------------------------------------
// PVQ index decoder package
// Shared control codes, command and status groups, and the pulse sign helper.
// ----------------------------------------------------------------------------
package pvq_pkg;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_IDLE,
    ST_TOP,
    ST_MP_P_ISS,
    ST_MP_P_CHK,
    ST_MP_Q_ISS,
    ST_MP_Q_CHK,
    ST_KD_ISS,
    ST_KD_CHK,
    ST_FL_ISS,
    ST_FL_CHK,
    ST_MD_P_ISS,
    ST_MD_P_CHK,
    ST_MD_Q_ISS,
    ST_MD_Q_CHK,
    ST_EMIT
  } pvq_state_t;

  typedef enum logic [1:0] {
    ST2_NONE,
    ST2_L2A,
    ST2_L2B,
    ST2_L2C
  } pvq_tail_t;

  typedef enum logic [2:0] {
    LK_NK1,
    LK_NN,
    LK_KM1N,
    LK_NK,
    LK_KN,
    LK_K1N
  } pvq_lk_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SIGN,
    OP_K_EQ_N,
    OP_K_DEC,
    OP_SET_P,
    OP_MD_ZERO,
    OP_ELEM,
    OP_L2A,
    OP_L2B,
    OP_L2C
  } pvq_op_t;

  typedef struct packed {
    pvq_lk_sel_t lk_sel;
    logic        lk_en;
    pvq_op_t     op;
  } pvq_cmd_t;

  typedef struct packed {
    logic fill_done;
    logic in_ok;
    logic n_gt2;
    logic k_ge_n;
    logic u_gt_i;
    logic md_zero;
    logic out_free;
  } pvq_stat_t;

  function automatic logic [8:0] spulse(input logic [8:0] mag, input logic [8:0] smask);
    return (mag + smask) ^ smask;
  endfunction

endpackage

// ===== src/pvq_if.sv =====
// ----------------------------------------------------------------------------
// PVQ index decoder channels
// Valid/ready channels for index items and pulse items.
// ----------------------------------------------------------------------------
interface pvq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_index;
  logic [6:0]  dimension;
  logic [7:0]  pulse_total;
  modport source(output valid, code_index, dimension, pulse_total, input ready);
  modport sink(input valid, code_index, dimension, pulse_total, output ready);
endinterface

interface pvq_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] pulse_value;
  logic              last_element;
  modport source(output valid, pulse_value, last_element, input ready);
  modport sink(input valid, pulse_value, last_element, output ready);
endinterface

// ===== src/pvq_index_to_pulses.sv =====
// ----------------------------------------------------------------------------
// PVQ index to pulses
// Decodes a combinatorial index into the signed pulses of a pyramid vector.
// ----------------------------------------------------------------------------
// After reset the block builds its U(a,b) table in an internal memory, one
// entry at a time; no item is taken during that time. One item is then
// decoded at a time. Each element passes through dispatch, its two fixed
// table reads and the output write, plus a table read for every step of the
// pulse search, as each read of the single table port takes an issue and a
// check state; the last two elements are made together without table reads.
// A full output register that is not taken holds the decoder at each step
// that writes the output. An item with a dimension or pulse count out of
// range is taken and gives no result. A finished element waits in the output
// register while work on the next one goes on.
module pvq_index_to_pulses import pvq_pkg::*; #(
  parameter int MAX_DIM    = 64,
  parameter int MAX_PULSES = 128
) (
  input  logic    clk,
  input  logic    rst_n,
  pvq_in_if.sink    in_ch,
  pvq_out_if.source out_ch
);

  localparam int ROWS = MAX_DIM + 1;
  localparam int COLS = MAX_DIM + MAX_PULSES + 2;
  localparam int AW   = $clog2(ROWS * COLS);

  pvq_cmd_t      cmd;
  pvq_stat_t     stat;
  logic          fill_done;
  logic          lk_en;
  logic [AW-1:0] lk_addr;
  logic [31:0]   lk_data;

  pvq_utab #(.ROWS(ROWS), .COLS(COLS)) u_utab (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (lk_en),
    .rd_addr  (lk_addr),
    .rd_data  (lk_data),
    .fill_done(fill_done)
  );

  pvq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  pvq_dp #(.MAX_DIM(MAX_DIM), .MAX_PULSES(MAX_PULSES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .fill_done  (fill_done),
    .code_index (in_ch.code_index),
    .dimension  (in_ch.dimension),
    .pulse_total(in_ch.pulse_total),
    .lk_en      (lk_en),
    .lk_addr    (lk_addr),
    .lk_data    (lk_data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_value  (out_ch.pulse_value),
    .out_last   (out_ch.last_element)
  );

endmodule

// ===== src/pvq_utab.sv =====
// ----------------------------------------------------------------------------
// PVQ U table
// Memory of U(a,b) values, filled by the recurrence after reset, then read.
// ----------------------------------------------------------------------------
module pvq_utab import pvq_pkg::*; #(
  parameter int ROWS  = 65,
  parameter int COLS  = 194,
  parameter int DEPTH = ROWS * COLS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  output logic          fill_done
);

  localparam int RAW = $clog2(ROWS);
  localparam int CBW = $clog2(COLS);

  logic [31:0]    mem [DEPTH];
  logic [31:0]    rdata_r;
  logic           done_r, done_nxt;
  logic           phase_r, phase_nxt;
  logic [RAW-1:0] a_r, a_nxt;
  logic [CBW-1:0] b_r, b_nxt;
  logic [AW-1:0]  waddr_r, waddr_nxt;
  logic [31:0]    left_r, left_nxt;
  logic [31:0]    diag_r, diag_nxt;
  logic           we;
  logic [31:0]    wdata;
  logic           re;
  logic [AW-1:0]  raddr;

  always_comb begin
    done_nxt  = done_r;
    phase_nxt = phase_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    waddr_nxt = waddr_r;
    left_nxt  = left_r;
    diag_nxt  = diag_r;
    we        = 1'b0;
    re        = rd_en;
    raddr     = rd_addr;
    if (a_r == '0) begin
      wdata = (b_r == '0) ? 32'd1 : 32'd0;
    end else if (b_r == '0) begin
      wdata = 32'd0;
    end else begin
      wdata = rdata_r + left_r + diag_r;
    end
    if (!done_r) begin
      re    = (phase_r == 1'b0) && (a_r != '0);
      raddr = waddr_r - AW'(COLS);
      if (phase_r == 1'b0) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        we        = 1'b1;
        left_nxt  = wdata;
        diag_nxt  = (a_r == '0) ? 32'd0 : rdata_r;
        waddr_nxt = waddr_r + AW'(1);
        if (b_r == CBW'(COLS - 1)) begin
          b_nxt = '0;
          a_nxt = a_r + RAW'(1);
          if (a_r == RAW'(ROWS - 1)) begin
            done_nxt = 1'b1;
          end
        end else begin
          b_nxt = b_r + CBW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      a_r     <= '0;
      b_r     <= '0;
      waddr_r <= '0;
    end else begin
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      waddr_r <= waddr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    diag_r <= diag_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr_r] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rd_data   = rdata_r;
  assign fill_done = done_r;

endmodule

// ===== src/pvq_ctrl.sv =====
// ----------------------------------------------------------------------------
// PVQ controller
// Sequences table lookups and datapath operations for one vector.
// ----------------------------------------------------------------------------
module pvq_ctrl import pvq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pvq_stat_t stat,
  output pvq_cmd_t  cmd
);

  pvq_state_t state_r, state_nxt;
  pvq_tail_t  tail_r, tail_nxt;

  always_comb begin
    state_nxt = state_r;
    tail_nxt  = tail_r;
    if (tail_r != ST2_NONE) begin
      unique case (tail_r)
        ST2_L2A: tail_nxt = ST2_L2B;
        ST2_L2B: if (stat.out_free) begin
          tail_nxt = ST2_L2C;
        end
        ST2_L2C: if (stat.out_free) begin
          tail_nxt  = ST2_NONE;
          state_nxt = ST_IDLE;
        end
        default: tail_nxt = ST2_NONE;
      endcase
    end else begin
      unique case (state_r)
        ST_FILL: if (stat.fill_done) begin
          state_nxt = ST_IDLE;
        end
        ST_IDLE: if (in_valid && stat.in_ok) begin
          state_nxt = ST_TOP;
        end
        ST_TOP: begin
          if (!stat.n_gt2) begin
            tail_nxt = ST2_L2A;
          end else if (stat.k_ge_n) begin
            state_nxt = ST_MP_P_ISS;
          end else begin
            state_nxt = ST_MD_P_ISS;
          end
        end
        ST_MP_P_ISS: state_nxt = ST_MP_P_CHK;
        ST_MP_P_CHK: state_nxt = ST_MP_Q_ISS;
        ST_MP_Q_ISS: state_nxt = ST_MP_Q_CHK;
        ST_MP_Q_CHK: state_nxt = stat.u_gt_i ? ST_KD_ISS : ST_FL_ISS;
        ST_KD_ISS:   state_nxt = ST_KD_CHK;
        ST_KD_CHK:   state_nxt = stat.u_gt_i ? ST_KD_ISS : ST_EMIT;
        ST_FL_ISS:   state_nxt = ST_FL_CHK;
        ST_FL_CHK:   state_nxt = stat.u_gt_i ? ST_FL_ISS : ST_EMIT;
        ST_MD_P_ISS: state_nxt = ST_MD_P_CHK;
        ST_MD_P_CHK: state_nxt = ST_MD_Q_ISS;
        ST_MD_Q_ISS: state_nxt = ST_MD_Q_CHK;
        ST_MD_Q_CHK: state_nxt = stat.md_zero ? ST_EMIT : ST_KD_ISS;
        ST_EMIT: if (stat.out_free) begin
          state_nxt = ST_TOP;
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.lk_sel = LK_NK;
    cmd.lk_en  = 1'b0;
    cmd.op     = OP_NONE;
    if (tail_r != ST2_NONE) begin
      unique case (tail_r)
        ST2_L2A: cmd.op = OP_L2A;
        ST2_L2B: if (stat.out_free) begin
          cmd.op = OP_L2B;
        end
        ST2_L2C: if (stat.out_free) begin
          cmd.op = OP_L2C;
        end
        default: cmd.op = OP_NONE;
      endcase
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          in_ready = 1'b1;
          if (in_valid && stat.in_ok) begin
            cmd.op = OP_LOAD;
          end
        end
        ST_MP_P_ISS: begin
          cmd.lk_sel = LK_NK1;
          cmd.lk_en  = 1'b1;
        end
        ST_MP_P_CHK: cmd.op = OP_SIGN;
        ST_MP_Q_ISS: begin
          cmd.lk_sel = LK_NN;
          cmd.lk_en  = 1'b1;
        end
        ST_MP_Q_CHK: if (stat.u_gt_i) begin
          cmd.op = OP_K_EQ_N;
        end
        ST_KD_ISS: begin
          cmd.lk_sel = LK_KM1N;
          cmd.lk_en  = 1'b1;
          cmd.op     = OP_K_DEC;
        end
        ST_KD_CHK: if (!stat.u_gt_i) begin
          cmd.op = OP_SET_P;
        end
        ST_FL_ISS: begin
          cmd.lk_sel = LK_NK;
          cmd.lk_en  = 1'b1;
        end
        ST_FL_CHK: cmd.op = stat.u_gt_i ? OP_K_DEC : OP_SET_P;
        ST_MD_P_ISS: begin
          cmd.lk_sel = LK_KN;
          cmd.lk_en  = 1'b1;
        end
        ST_MD_P_CHK: cmd.op = OP_SET_P;
        ST_MD_Q_ISS: begin
          cmd.lk_sel = LK_K1N;
          cmd.lk_en  = 1'b1;
        end
        ST_MD_Q_CHK: cmd.op = stat.md_zero ? OP_MD_ZERO : OP_SIGN;
        ST_EMIT: if (stat.out_free) begin
          cmd.op = OP_ELEM;
        end
        default: cmd.op = OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      tail_r  <= ST2_NONE;
    end else begin
      state_r <= state_nxt;
      tail_r  <= tail_nxt;
    end
  end

endmodule

// ===== src/pvq_dp.sv =====
// ----------------------------------------------------------------------------
// PVQ datapath
// Index, dimension and pulse registers, table addressing and the output stage.
// ----------------------------------------------------------------------------
module pvq_dp import pvq_pkg::*; #(
  parameter int MAX_DIM    = 64,
  parameter int MAX_PULSES = 128,
  parameter int ROWS       = MAX_DIM + 1,
  parameter int COLS       = MAX_DIM + MAX_PULSES + 2,
  parameter int AW         = $clog2(ROWS * COLS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pvq_cmd_t          cmd,
  output pvq_stat_t         stat,
  input  logic              fill_done,
  input  logic [31:0]       code_index,
  input  logic [6:0]        dimension,
  input  logic [7:0]        pulse_total,
  output logic              lk_en,
  output logic [AW-1:0]     lk_addr,
  input  logic [31:0]       lk_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [8:0] out_value,
  output logic              out_last
);

  localparam int KW = $clog2(COLS) + 2;
  localparam int NW = $clog2(MAX_DIM + 1);

  logic [31:0]          i_r, i_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic signed [KW-1:0] k_r, k_nxt;
  logic signed [KW-1:0] k0_r, k0_nxt;
  logic                 s_r, s_nxt;
  logic [31:0]          p_r, p_nxt;
  logic [8:0]           k2_r, k2_nxt;
  logic                 zero_r;
  logic                 ov_r, ov_nxt;
  logic [8:0]           oval_r, oval_nxt;
  logic                 olast_r, olast_nxt;

  logic signed [KW-1:0] n_s, la, lb;
  logic                 direct, swap;
  logic [KW-1:0]        row_u, col_u;
  logic [31:0]          u;
  logic                 out_free;
  logic [31:0]          k_ext, p2, i_inc, k2w;

  assign n_s = signed'(KW'(n_r));

  always_comb begin
    unique case (cmd.lk_sel)
      LK_NK1:  begin la = n_s;                lb = k_r + KW'(1); end
      LK_NN:   begin la = n_s;                lb = n_s;          end
      LK_KM1N: begin la = k_r - KW'(1);       lb = n_s;          end
      LK_NK:   begin la = n_s;                lb = k_r;          end
      LK_KN:   begin la = k_r;                lb = n_s;          end
      LK_K1N:  begin la = k_r + KW'(1);       lb = n_s;          end
      default: begin la = k_r;                lb = n_s;          end
    endcase
    direct = (la >= 0) && (lb >= 0) && (la < signed'(KW'(ROWS)))
           && (lb < signed'(KW'(COLS)));
    swap   = (la >= 0) && (lb >= 0) && (lb < signed'(KW'(ROWS)))
           && (la < signed'(KW'(COLS)));
    row_u  = direct ? unsigned'(la) : unsigned'(lb);
    col_u  = direct ? unsigned'(lb) : unsigned'(la);
    lk_addr = AW'(AW'(row_u) * AW'(COLS) + AW'(col_u));
  end

  assign lk_en    = cmd.lk_en;
  assign u        = zero_r ? 32'd0 : lk_data;
  assign out_free = !ov_r || out_ready;
  assign k_ext    = {{(32 - KW){k_r[KW-1]}}, k_r};
  assign p2       = (k_ext << 1) + 32'd1;
  assign i_inc    = i_r + 32'd1;
  assign k2w      = i_inc >> 1;

  always_comb begin
    i_nxt     = i_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    k0_nxt    = k0_r;
    s_nxt     = s_r;
    p_nxt     = p_r;
    k2_nxt    = k2_r;
    ov_nxt    = ov_r && !out_ready;
    oval_nxt  = oval_r;
    olast_nxt = olast_r;
    unique case (cmd.op)
      OP_NONE: ;
      OP_LOAD: begin
        i_nxt = code_index;
        n_nxt = NW'(dimension);
        k_nxt = KW'(pulse_total);
      end
      OP_SIGN: begin
        s_nxt  = (i_r >= u);
        i_nxt  = (i_r >= u) ? (i_r - u) : i_r;
        k0_nxt = k_r;
      end
      OP_K_EQ_N: k_nxt = n_s;
      OP_K_DEC:  k_nxt = k_r - KW'(1);
      OP_SET_P:  p_nxt = u;
      OP_MD_ZERO: begin
        k0_nxt = k_r;
        s_nxt  = 1'b0;
      end
      OP_ELEM: begin
        i_nxt     = i_r - p_r;
        n_nxt     = n_r - NW'(1);
        ov_nxt    = 1'b1;
        oval_nxt  = spulse(9'(k0_r - k_r), {9{s_r}});
        olast_nxt = 1'b0;
      end
      OP_L2A: begin
        s_nxt = (i_r >= p2);
        i_nxt = (i_r >= p2) ? (i_r - p2) : i_r;
      end
      OP_L2B: begin
        k2_nxt    = k2w[8:0];
        i_nxt     = (k2w != 32'd0) ? (i_r - ((k2w << 1) - 32'd1)) : i_r;
        ov_nxt    = 1'b1;
        oval_nxt  = spulse(9'(k_r) - k2w[8:0], {9{s_r}});
        olast_nxt = 1'b0;
      end
      OP_L2C: begin
        ov_nxt    = 1'b1;
        oval_nxt  = spulse(k2_r, 9'(32'd0 - i_r));
        olast_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    k_r     <= k_nxt;
    k0_r    <= k0_nxt;
    s_r     <= s_nxt;
    p_r     <= p_nxt;
    k2_r    <= k2_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
    if (cmd.lk_en) begin
      zero_r <= !(direct || swap);
    end
  end

  assign stat.fill_done = fill_done;
  assign stat.in_ok     = (dimension >= 7'd2) && (32'(dimension) <= MAX_DIM)
                        && (pulse_total >= 8'd1) && (32'(pulse_total) <= MAX_PULSES);
  assign stat.n_gt2     = (n_r > NW'(2));
  assign stat.k_ge_n    = (k_r >= n_s);
  assign stat.u_gt_i    = (u > i_r);
  assign stat.md_zero   = (p_r <= i_r) && (i_r < u);
  assign stat.out_free  = out_free;

  assign out_valid = ov_r;
  assign out_value = signed'(oval_r);
  assign out_last  = olast_r;

endmodule

// ===== src/pvq_checker.sv =====
// ----------------------------------------------------------------------------
// PVQ port checker
// Checks the decoder's port behavior over time; bound to the top level.
// ----------------------------------------------------------------------------
module pvq_checker #(
  parameter int MaxDim    = 64,
  parameter int MaxPulses = 128
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [6:0] dimension,
  input logic [7:0] pulse_total,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] pulse_value,
  input logic       last_element
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pulse_value) && $stable(last_element))
    else $error("Result item changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && dimension >= 7'd2 && 32'(dimension) <= MaxDim
    && pulse_total >= 8'd1 && 32'(pulse_total) <= MaxPulses |=> !in_ready)
    else $error("Input taken again while a vector is in progress.");

  a_mid_vector_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_element |-> !in_ready)
    else $error("Input ready before the vector was complete.");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("Channels active right after reset.");

endmodule

bind pvq_index_to_pulses pvq_checker #(.MaxDim(MAX_DIM), .MaxPulses(MAX_PULSES))
  u_pvq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .dimension   (in_ch.dimension),
  .pulse_total (in_ch.pulse_total),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pulse_value (out_ch.pulse_value),
  .last_element(out_ch.last_element)
);

// ===== sim/tb_pvq_index_to_pulses.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PVQ index to pulses testbench
// Sends index items to the decoder and checks every pulse item it returns
// against a cycle-free predictor of the CWRS decoding steps. Both channels
// idle at random, the receiver holds off once for a long stretch, and the
// last part of the run has no idling at all.
// ----------------------------------------------------------------------------
module tb_pvq_index_to_pulses;
  import pvq_pkg::*;

  localparam int MAX_DIM    = 64;
  localparam int MAX_PULSES = 128;
  localparam int U_ROWS     = MAX_DIM + 1;
  localparam int U_COLS     = MAX_DIM + MAX_PULSES + 2;
  localparam int IDLE_LIMIT = 100000;
  localparam int DRAIN_WAIT = 400;

  typedef struct packed {
    logic signed [8:0] pulse_value;
    logic              last_element;
  } pulse_t;

  logic clk;
  logic rst_n;

  pvq_in_if  in_ch();
  pvq_out_if out_ch();

  pvq_index_to_pulses #(.MAX_DIM(MAX_DIM), .MAX_PULSES(MAX_PULSES)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic [31:0] u_count_tab[0:U_ROWS-1][0:U_COLS-1];
  pulse_t      pulses_due[$];
  int          errors;
  int          idle_cycles;
  int          stall_left;
  int          long_hold;
  bit          idling_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] u_count(input int a, input int b);
    if (a < 0 || b < 0) return 32'd0;
    if (a < U_ROWS && b < U_COLS) return u_count_tab[a][b];
    if (b < U_ROWS && a < U_COLS) return u_count_tab[b][a];
    return 32'd0;
  endfunction

  function automatic logic [8:0] signed_mag(input logic [31:0] mag, input logic [31:0] smask);
    logic [31:0] r;
    r = (mag + smask) ^ smask;
    return r[8:0];
  endfunction

  task automatic push_pulse(input logic [8:0] v, input logic last);
    pulse_t e;
    e.pulse_value  = v;
    e.last_element = last;
    pulses_due.push_back(e);
  endtask

  // Works out the pulses of one accepted index item.
  task automatic predict_pulses(input logic [31:0] idx, input int n_in, input int k_in);
    int          n;
    int          k;
    int          k0;
    logic [31:0] i;
    logic [31:0] p;
    logic [31:0] q;
    logic [31:0] s;
    logic [31:0] k2;
    logic [8:0]  v;
    n = n_in;
    k = k_in;
    i = idx;
    if (n < 2 || n > MAX_DIM || k < 1 || k > MAX_PULSES) return;
    while (n > 2) begin
      if (k >= n) begin
        p = u_count(n, k + 1);
        s = (i >= p) ? 32'hFFFF_FFFF : 32'd0;
        i -= p & s;
        k0 = k;
        q = u_count(n, n);
        if (q > i) begin
          k = n;
          do begin
            k--;
            p = u_count(k, n);
          end while (p > i);
        end else begin
          p = u_count(n, k);
          while (p > i) begin
            k--;
            p = u_count(n, k);
          end
        end
        i -= p;
        v = signed_mag(32'(k0 - k), s);
      end else begin
        p = u_count(k, n);
        q = u_count(k + 1, n);
        if (p <= i && i < q) begin
          i -= p;
          v = 9'd0;
        end else begin
          s = (i >= q) ? 32'hFFFF_FFFF : 32'd0;
          i -= q & s;
          k0 = k;
          do begin
            k--;
            p = u_count(k, n);
          end while (p > i);
          i -= p;
          v = signed_mag(32'(k0 - k), s);
        end
      end
      push_pulse(v, 1'b0);
      n--;
    end
    p = 32'(2 * k + 1);
    s = (i >= p) ? 32'hFFFF_FFFF : 32'd0;
    i -= p & s;
    k2 = (i + 32'd1) >> 1;
    if (k2 != 0) i -= 2 * k2 - 1;
    push_pulse(signed_mag(32'(k) - k2, s), 1'b0);
    push_pulse(signed_mag(k2, 32'd0 - i), 1'b1);
  endtask

  task automatic send_index(input logic [31:0] idx, input int n, input int k);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.code_index  = idx;
    in_ch.dimension   = 7'(n);
    in_ch.pulse_total = 8'(k);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_pulses(idx, n, k);
    @(negedge clk);
  endtask

  task automatic send_random(input bit wide);
    int          n;
    int          k;
    logic [31:0] vol;
    logic [31:0] idx;
    n = wide ? $urandom_range(2, MAX_DIM) : $urandom_range(2, 8);
    k = wide ? $urandom_range(1, MAX_PULSES) : $urandom_range(1, 12);
    vol = u_count(n, k) + u_count(n, k + 1);
    idx = $urandom;
    if ($urandom_range(0, 9) != 0 && vol != 0) idx = idx % vol;
    send_index(idx, n, k);
  endtask

  task automatic test_extremes();
    send_index(32'd0, 2, 1);
    send_index(32'd3, 2, 1);
    send_index(32'd0, MAX_DIM, MAX_PULSES);
    send_index(32'hFFFF_FFFF, MAX_DIM, MAX_PULSES);
    send_index(32'd12345, MAX_DIM, 1);
    send_index(32'd77, 2, MAX_PULSES);
    send_index(32'd5, 5, 3);
    send_index(32'd5, 3, 5);
    send_index(32'hFFFF_FFFF, 2, 1);
    send_index(32'hAAAA_5555, 4, 4);
    send_index(32'd0, 7, 6);
  endtask

  task automatic test_out_of_range();
    send_index(32'd1, 0, 4);
    send_index(32'd1, 1, 4);
    send_index(32'd1, MAX_DIM + 1, 4);
    send_index(32'd1, 127, 4);
    send_index(32'd1, 4, 0);
    send_index(32'd1, 4, MAX_PULSES + 1);
    send_index(32'd1, 4, 255);
    send_index(32'd2, 3, 2);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_random($urandom_range(0, 9) == 0);
  endtask

  task automatic test_backpressure();
    long_hold = 300;
    repeat (8) send_random(1'b0);
  endtask

  task automatic test_no_idle();
    idling_on = 1'b0;
    repeat (25) send_random($urandom_range(0, 7) == 0);
  endtask

  initial begin
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        stall_left = long_hold;
        long_hold  = 0;
      end else if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pulse_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pulses_due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected pulse item: value %0d last %0b",
                   out_ch.pulse_value, out_ch.last_element);
        end
      end else begin
        e = pulses_due.pop_front();
        if (out_ch.pulse_value !== e.pulse_value || out_ch.last_element !== e.last_element) begin
          errors++;
          if (errors <= 10) begin
            $display("pulse mismatch: expected value %0d last %0b, got value %0d last %0b",
                     e.pulse_value, e.last_element, out_ch.pulse_value,
                     out_ch.last_element);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    errors            = 0;
    idle_cycles       = 0;
    long_hold         = 0;
    idling_on         = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.code_index  = '0;
    in_ch.dimension   = '0;
    in_ch.pulse_total = '0;
    for (int a = 0; a < U_ROWS; a++) begin
      for (int b = 0; b < U_COLS; b++) begin
        if (a == 0) begin
          u_count_tab[a][b] = (b == 0) ? 32'd1 : 32'd0;
        end else if (b == 0) begin
          u_count_tab[a][b] = 32'd0;
        end else begin
          u_count_tab[a][b] = u_count_tab[a-1][b] + u_count_tab[a][b-1]
                            + u_count_tab[a-1][b-1];
        end
      end
    end
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_out_of_range();
    test_random(50);
    test_backpressure();
    test_random(40);
    test_no_idle();

    in_ch.valid = 1'b0;
    while (pulses_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pvq_pkg.sv
src/pvq_if.sv
src/pvq_utab.sv
src/pvq_ctrl.sv
src/pvq_dp.sv
src/pvq_index_to_pulses.sv
src/pvq_checker.sv
sim/tb_pvq_index_to_pulses.sv
